/* hw/rtl/scancode_to_char_fifo_assert.svh */
// assertion macros used by the top-level rtl file
`ifndef SCANCODE_TO_CHAR_FIFO_ASSERT_SVH
`define SCANCODE_TO_CHAR_FIFO_ASSERT_SVH

// combinational or same-cycle implication, checked at every clock edge out of reset
`define SC2C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define SC2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sc2c_pkg.sv */
// shared types, constants and key tables for the scancode to char fifo
package sc2c_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NumCfg  = 6;
  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_LEFT  = 3'd0,
    CFG_RIGHT = 3'd1,
    CFG_UP    = 3'd2,
    CFG_DOWN  = 3'd3,
    CFG_HOME  = 3'd4,
    CFG_END   = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
  localparam logic [7:0] SC_RELEASE    = 8'h80;
  localparam logic [6:0] SC_LSHIFT     = 7'h2A;
  localparam logic [6:0] SC_RSHIFT     = 7'h36;
  localparam logic [6:0] SC_CAPS       = 7'h3A;
  localparam logic [6:0] SC_LEFT       = 7'h4B;
  localparam logic [6:0] SC_RIGHT      = 7'h4D;
  localparam logic [6:0] SC_UP         = 7'h48;
  localparam logic [6:0] SC_DOWN       = 7'h50;
  localparam logic [6:0] SC_HOME       = 7'h47;
  localparam logic [6:0] SC_END        = 7'h4F;

  typedef logic [NumCfg-1:0][CharW-1:0] code_arr_t;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] data;
  } push_req_t;

  typedef struct packed {
    logic             empty;
    logic [CharW-1:0] head;
    logic             nonempty_next;
  } fifo_stat_t;

  function automatic logic [7:0] plain_map(input logic [6:0] k);
    logic [7:0] c;
    case (k)
      7'd1:  c = 8'd27;
      7'd2:  c = "1";
      7'd3:  c = "2";
      7'd4:  c = "3";
      7'd5:  c = "4";
      7'd6:  c = "5";
      7'd7:  c = "6";
      7'd8:  c = "7";
      7'd9:  c = "8";
      7'd10: c = "9";
      7'd11: c = "0";
      7'd12: c = "-";
      7'd13: c = "=";
      7'd14: c = 8'd8;
      7'd15: c = 8'd9;
      7'd16: c = "q";
      7'd17: c = "w";
      7'd18: c = "e";
      7'd19: c = "r";
      7'd20: c = "t";
      7'd21: c = "y";
      7'd22: c = "u";
      7'd23: c = "i";
      7'd24: c = "o";
      7'd25: c = "p";
      7'd26: c = 8'h5B;
      7'd27: c = 8'h5D;
      7'd28: c = 8'd10;
      7'd30: c = "a";
      7'd31: c = "s";
      7'd32: c = "d";
      7'd33: c = "f";
      7'd34: c = "g";
      7'd35: c = "h";
      7'd36: c = "j";
      7'd37: c = "k";
      7'd38: c = "l";
      7'd39: c = 8'h3B;
      7'd40: c = 8'h27;
      7'd41: c = 8'h60;
      7'd43: c = 8'h5C;
      7'd44: c = "z";
      7'd45: c = "x";
      7'd46: c = "c";
      7'd47: c = "v";
      7'd48: c = "b";
      7'd49: c = "n";
      7'd50: c = "m";
      7'd51: c = 8'h2C;
      7'd52: c = 8'h2E;
      7'd53: c = 8'h2F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      7'd74: c = 8'h2D;
      7'd78: c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] upper_map(input logic [6:0] k);
    logic [7:0] c;
    case (k)
      7'd1:  c = 8'd27;
      7'd2:  c = 8'h21;
      7'd3:  c = 8'h40;
      7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;
      7'd6:  c = 8'h25;
      7'd7:  c = 8'h5E;
      7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;
      7'd10: c = 8'h28;
      7'd11: c = 8'h29;
      7'd12: c = 8'h5F;
      7'd13: c = 8'h2B;
      7'd14: c = 8'd8;
      7'd15: c = 8'd9;
      7'd16: c = "Q";
      7'd17: c = "W";
      7'd18: c = "E";
      7'd19: c = "R";
      7'd20: c = "T";
      7'd21: c = "Y";
      7'd22: c = "U";
      7'd23: c = "I";
      7'd24: c = "O";
      7'd25: c = "P";
      7'd26: c = 8'h7B;
      7'd27: c = 8'h7D;
      7'd28: c = 8'd10;
      7'd30: c = "A";
      7'd31: c = "S";
      7'd32: c = "D";
      7'd33: c = "F";
      7'd34: c = "G";
      7'd35: c = "H";
      7'd36: c = "J";
      7'd37: c = "K";
      7'd38: c = "L";
      7'd39: c = 8'h3A;
      7'd40: c = 8'h22;
      7'd41: c = 8'h7E;
      7'd43: c = 8'h7C;
      7'd44: c = "Z";
      7'd45: c = "X";
      7'd46: c = "C";
      7'd47: c = "V";
      7'd48: c = "B";
      7'd49: c = "N";
      7'd50: c = "M";
      7'd51: c = 8'h3C;
      7'd52: c = 8'h3E;
      7'd53: c = 8'h3F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      7'd74: c = 8'h2D;
      7'd78: c = 8'h2B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sc2c_decode.sv */
// scancode decoder with shift, caps lock and extended prefix state
module sc2c_decode
  import sc2c_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  input  code_arr_t  codes_i,
  output push_req_t  push_o
);

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic ext_q, ext_d;
  logic [7:0] ch;
  logic [6:0] key;

  assign key = byte_i[6:0];

  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    ext_d   = ext_q;
    ch      = 8'h00;
    if (byte_i == SC_EXT_PREFIX) begin
      ext_d = 1'b1;
    end else if ((byte_i & SC_RELEASE) != 8'h00) begin
      if (key == SC_LSHIFT || key == SC_RSHIFT) begin
        shift_d = 1'b0;
      end
      ext_d = 1'b0;
    end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
      shift_d = 1'b1;
    end else if (key == SC_CAPS) begin
      caps_d = ~caps_q;
    end else if (ext_q) begin
      case (key)
        SC_LEFT:  ch = codes_i[CFG_LEFT];
        SC_RIGHT: ch = codes_i[CFG_RIGHT];
        SC_UP:    ch = codes_i[CFG_UP];
        SC_DOWN:  ch = codes_i[CFG_DOWN];
        SC_HOME:  ch = codes_i[CFG_HOME];
        SC_END:   ch = codes_i[CFG_END];
        default:  ch = 8'h00;
      endcase
      ext_d = 1'b0;
    end else if (shift_q ^ caps_q) begin
      ch = upper_map(key);
    end else begin
      ch = plain_map(key);
    end
  end

  assign push_o.valid = en_i && (ch != 8'h00);
  assign push_o.data  = ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
      ext_q   <= 1'b0;
    end else if (en_i) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
      ext_q   <= ext_d;
    end
  end

endmodule

/* hw/rtl/sc2c_fifo.sv */
// ring buffer that drops its oldest word when full, with prefetched head
module sc2c_fifo
  import sc2c_pkg::*;
#(
  parameter int unsigned Depth = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_req_t  push_i,
  input  logic       pop_i,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  logic [CharW-1:0] mem [Depth];
  logic [CharW-1:0] head_q;
  logic [PtrW-1:0]  rd_q, rd_d;
  logic [PtrW-1:0]  wr_q, wr_d;
  logic [PtrW-1:0]  wr_inc, rd_inc;
  logic             empty;
  logic             full;
  logic             do_pop;

  assign wr_inc = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
  assign rd_inc = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
  assign empty  = (rd_q == wr_q);
  assign full   = (wr_inc == rd_q);
  assign do_pop = pop_i && !empty;

  always_comb begin
    rd_d = rd_q;
    wr_d = wr_q;
    if (push_i.valid) begin
      wr_d = wr_inc;
      if (full) begin
        rd_d = rd_inc;
      end
    end else if (do_pop) begin
      rd_d = rd_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem[wr_q] <= push_i.data;
    end
  end

  // head word for the next cycle, with write bypass
  always_ff @(posedge clk_i) begin
    if (push_i.valid && (wr_q == rd_d)) begin
      head_q <= push_i.data;
    end else begin
      head_q <= mem[rd_d];
    end
  end

  assign stat_o.empty         = empty;
  assign stat_o.head          = head_q;
  assign stat_o.nonempty_next = (rd_d != wr_d);

endmodule

/* hw/rtl/scancode_to_char_fifo.sv */
// top level: input and result registers, config registers, decoder and fifo
// Set 1 scancode bytes come in with action low and, unless from_aux_i is high,
// are decoded into characters that fill a ring buffer of FIFO_DEPTH entries
// holding up to FIFO_DEPTH-1 words; when full the oldest word is dropped. An item
// with action high pops one word (char_valid_o low and char_out_o zero when
// empty); every item gives one result, which also tells whether words remain.
// One item is taken per cycle while the result side keeps up. An accepted item
// loads the input register; its decode, table lookup and pointer update then go
// into the result register once that is free. A stalled result holds the input
// register, so the input stalls with it. The head word is prefetched from the
// buffer memory into a register, so a pop needs no separate memory read. Buffer
// contents need no clearing after reset. Code registers are written via cfg_we_i,
// cfg_addr_i and cfg_wdata_i; the user must do so only while idle (not enforced).
module scancode_to_char_fifo
  import sc2c_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [7:0]          data_byte_i,
  input  logic                from_aux_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                char_valid_o,
  output logic [7:0]          char_out_o,
  output logic                has_input_o,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CharW-1:0]    cfg_wdata_i
);

  `include "scancode_to_char_fifo_assert.svh"

  code_arr_t  codes_q;
  logic       in_valid_q;
  logic       action_q;
  logic [7:0] byte_q;
  logic       aux_q;
  logic       adv;
  logic       dec_en;
  logic       pop;
  push_req_t  push;
  fifo_stat_t stat;
  logic       out_valid_q;
  logic       char_valid_q, char_valid_d;
  logic [7:0] char_out_q, char_out_d;
  logic       has_input_q;

  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign dec_en     = adv && !action_q && !aux_q;
  assign pop        = adv && action_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q[CFG_LEFT]  <= 8'd128;
      codes_q[CFG_RIGHT] <= 8'd129;
      codes_q[CFG_UP]    <= 8'd130;
      codes_q[CFG_DOWN]  <= 8'd131;
      codes_q[CFG_HOME]  <= 8'd132;
      codes_q[CFG_END]   <= 8'd133;
    end else if (cfg_we_i && (cfg_addr_i <= CFG_END)) begin
      codes_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q <= action_i;
      byte_q   <= data_byte_i;
      aux_q    <= from_aux_i;
    end
  end

  sc2c_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (dec_en),
    .byte_i  (byte_q),
    .codes_i (codes_q),
    .push_o  (push)
  );

  sc2c_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (stat)
  );

  always_comb begin
    char_valid_d = 1'b0;
    char_out_d   = 8'h00;
    if (action_q && !stat.empty) begin
      char_valid_d = 1'b1;
      char_out_d   = stat.head;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      char_valid_q <= char_valid_d;
      char_out_q   <= char_out_d;
      has_input_q  <= stat.nonempty_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = char_valid_q;
  assign char_out_o   = char_out_q;
  assign has_input_o  = has_input_q;

  `SC2C_ASSERT(a_popped_char_nonzero, out_valid_q && char_valid_q |-> char_out_q != 8'h00,
               "popped word is zero")
  `SC2C_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_q, "result register not loaded")
  `SC2C_ASSERT(a_out_from_in, $rose(out_valid_q) |-> $past(in_valid_q),
               "result appeared without an input word")
  `SC2C_ASSERT(a_pop_keeps_state, pop |-> !push.valid, "push and pop in one word")

endmodule

/* verif/tb_scancode_to_char_fifo.sv */
// testbench for scancode_to_char_fifo: scan code and pop stimulus checked against a key decoder model
`timescale 1ns / 100ps

module tb_scancode_to_char_fifo;
  import sc2c_pkg::*;

  typedef struct packed {
    logic       got;
    logic [7:0] chr;
    logic       more;
  } key_res_t;

  typedef struct packed {
    logic       pop;
    logic [7:0] code;
    logic       aux;
    logic       typed;
    key_res_t   want;
  } key_step_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

  localparam int       HALF_PERIOD = 5;
  localparam int       IDLE_LIMIT  = 2000;
  localparam logic [7:0] KEY_A = 8'h1E;
  localparam logic [7:0] KEY_1 = 8'h02;
  localparam logic [7:0] KEY_2 = 8'h03;
  localparam logic [7:0] KEY_Q = 8'h10;
  localparam key_res_t NO_CHAR = '0;
  localparam logic [6:0] EXT_KEYS [6] = '{SC_LEFT, SC_RIGHT, SC_UP, SC_DOWN, SC_HOME, SC_END};

  localparam key_step_t DIRECTED [28] = '{
    '{1'b1, 8'h00, 1'b0, 1'b1, NO_CHAR},
    '{1'b0, 8'h00, 1'b0, 1'b1, NO_CHAR},
    '{1'b0, 8'hFF, 1'b1, 1'b1, NO_CHAR},
    '{1'b0, 8'h7F, 1'b0, 1'b1, NO_CHAR},
    '{1'b0, KEY_A, 1'b0, 1'b0, NO_CHAR},
    '{1'b1, 8'hFF, 1'b1, 1'b1, '{1'b1, "a", 1'b0}},
    '{1'b0, {1'b0, SC_LSHIFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, KEY_A, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b1, SC_LSHIFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_CAPS}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, KEY_1, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_RSHIFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, KEY_2, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b1, SC_RSHIFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_CAPS}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, SC_EXT_PREFIX, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, SC_EXT_PREFIX, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_LEFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, SC_EXT_PREFIX, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_LSHIFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_END}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b1, SC_LSHIFT}, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, SC_EXT_PREFIX, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, KEY_Q, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, KEY_Q, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, SC_EXT_PREFIX, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, SC_RELEASE, 1'b0, 1'b0, NO_CHAR},
    '{1'b0, {1'b0, SC_HOME}, 1'b0, 1'b0, NO_CHAR}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                action_i    = 1'b0;
  logic [7:0]          data_byte_i = 8'h00;
  logic                from_aux_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                char_valid_o;
  logic [7:0]          char_out_o;
  logic                has_input_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CharW-1:0]    cfg_wdata_i = '0;

  // decoder model state, pointers wrap at the default depth of 256
  logic [7:0] lower_tab [128];
  logic [7:0] upper_tab [128];
  logic [7:0] key_codes [NumCfg];
  logic [7:0] char_ring [256];
  logic [7:0] rd_ptr, wr_ptr;
  logic       shift_down, caps_set, ext_armed;

  key_res_t    owed_chars [$];
  int          burst_left;
  int          mismatches;
  int          idle_cycles;
  int          words_in, chars_read, overflow_drops;
  int          stall_cycle;
  stall_mode_e stall_mode = STALL_NONE;

  scancode_to_char_fifo uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .from_aux_i   (from_aux_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_valid_o (char_valid_o),
    .char_out_o   (char_out_o),
    .has_input_o  (has_input_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  task automatic fill_row(input int first, input string lo, input string up);
    for (int i = 0; i < lo.len(); i++) begin
      lower_tab[first + i] = lo[i];
      upper_tab[first + i] = up[i];
    end
  endtask

  initial begin
    foreach (lower_tab[i]) begin
      lower_tab[i] = 8'h00;
      upper_tab[i] = 8'h00;
    end
    fill_row(2, "1234567890-=", "!@#$%^&*()_+");
    fill_row(16, "qwertyuiop[]", "QWERTYUIOP{}");
    fill_row(30, "asdfghjkl;'", "ASDFGHJKL:\"");
    fill_row(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
    fill_row(55, "*", "*");
    fill_row(57, " ", " ");
    fill_row(74, "-", "-");
    fill_row(78, "+", "+");
    lower_tab[41] = 8'h60;
    upper_tab[41] = 8'h7E;
    // control keys: escape, backspace, tab, enter
    lower_tab[1]  = 8'd27;
    upper_tab[1]  = 8'd27;
    lower_tab[14] = 8'd8;
    upper_tab[14] = 8'd8;
    lower_tab[15] = 8'd9;
    upper_tab[15] = 8'd9;
    lower_tab[28] = 8'd10;
    upper_tab[28] = 8'd10;
    for (int i = 0; i < NumCfg; i++) key_codes[i] = 8'd128 + 8'(i);
    rd_ptr     = '0;
    wr_ptr     = '0;
    shift_down = 1'b0;
    caps_set   = 1'b0;
    ext_armed  = 1'b0;
  end

  function automatic key_res_t decode_key_event(input logic pop, input logic [7:0] code,
                                                input logic aux);
    key_res_t   r;
    logic [7:0] ch;
    logic [6:0] k;
    r  = '0;
    ch = '0;
    k  = code[6:0];
    if (pop) begin
      if (rd_ptr != wr_ptr) begin
        r.got = 1'b1;
        r.chr = char_ring[rd_ptr];
        rd_ptr++;
        chars_read++;
      end
    end else if (!aux) begin
      if (code == SC_EXT_PREFIX) begin
        ext_armed = 1'b1;
      end else if ((code & SC_RELEASE) != 0) begin
        if (k == SC_LSHIFT || k == SC_RSHIFT) shift_down = 1'b0;
        ext_armed = 1'b0;
      end else if (k == SC_LSHIFT || k == SC_RSHIFT) begin
        shift_down = 1'b1;
      end else if (k == SC_CAPS) begin
        caps_set = ~caps_set;
      end else begin
        if (ext_armed) begin
          case (k)
            SC_LEFT:  ch = key_codes[CFG_LEFT];
            SC_RIGHT: ch = key_codes[CFG_RIGHT];
            SC_UP:    ch = key_codes[CFG_UP];
            SC_DOWN:  ch = key_codes[CFG_DOWN];
            SC_HOME:  ch = key_codes[CFG_HOME];
            SC_END:   ch = key_codes[CFG_END];
            default:  ch = 8'h00;
          endcase
          ext_armed = 1'b0;
        end else if (shift_down ^ caps_set) begin
          ch = upper_tab[k];
        end else begin
          ch = lower_tab[k];
        end
        if (ch != 0) begin
          // full ring drops its oldest word
          if (wr_ptr + 8'd1 == rd_ptr) begin
            rd_ptr++;
            overflow_drops++;
          end
          char_ring[wr_ptr] = ch;
          wr_ptr++;
        end
      end
    end
    r.more = (rd_ptr != wr_ptr);
    return r;
  endfunction

  task automatic put_word(input logic pop, input logic [7:0] code, input logic aux,
                          input logic typed = 1'b0, input key_res_t want = '0);
    key_res_t predicted;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    action_i    <= pop;
    data_byte_i <= code;
    from_aux_i  <= aux;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = decode_key_event(pop, code, aux);
    owed_chars.push_back(typed ? want : predicted);
    burst_left--;
    words_in++;
  endtask

  task automatic random_event(input int pop_pct);
    logic [7:0] code;
    int         pick;
    code = 8'($urandom);
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < pop_pct) begin
      put_word(1'b1, code, 1'($urandom));
    end else if (pick == 0) begin
      put_word(1'b0, code, 1'b1);
    end else if (pick <= 3) begin
      put_word(1'b0, SC_EXT_PREFIX, 1'b0);
      // prefix followed by a stray byte now and then
      if (pick == 3) put_word(1'b0, code, 1'b0);
      else put_word(1'b0, {1'b0, EXT_KEYS[$urandom_range(0, 5)]}, 1'b0);
    end else if (pick == 4) begin
      put_word(1'b0, {1'($urandom), ($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT)}, 1'b0);
    end else if (pick == 5) begin
      put_word(1'b0, {1'b0, SC_CAPS}, 1'b0);
    end else if (pick <= 7) begin
      put_word(1'b0, code, 1'b0);
    end else begin
      put_word(1'b0, {1'b0, 7'($urandom_range(1, 57))}, 1'b0);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic load_codes(input logic [NumCfg-1:0][7:0] vals);
    for (int i = 0; i < NumCfg; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      key_codes[i] = vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    stall_cycle++;
    if (stall_cycle % 64 == 0) stall_mode = stall_mode_e'($urandom_range(0, 2));
    case (stall_mode)
      STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 99) < 35);
      STALL_PERIODIC: out_stall_i <= (stall_cycle % 5) < 2;
      default:        out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    key_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_chars.size() == 0) begin
        $display("%0t: word with nothing owed: char_valid %0b char_out %02h has_input %0b",
                 $time, char_valid_o, char_out_o, has_input_o);
        mismatches++;
      end else begin
        exp_res = owed_chars.pop_front();
        if (char_valid_o !== exp_res.got) begin
          $display("%0t: char_valid expected %0b actual %0b", $time, exp_res.got, char_valid_o);
          mismatches++;
        end
        if (char_out_o !== exp_res.chr) begin
          $display("%0t: char_out expected %02h actual %02h", $time, exp_res.chr, char_out_o);
          mismatches++;
        end
        if (has_input_o !== exp_res.more) begin
          $display("%0t: has_input expected %0b actual %0b", $time, exp_res.more, has_input_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++)
      put_word(DIRECTED[i].pop, DIRECTED[i].code, DIRECTED[i].aux,
               DIRECTED[i].typed, DIRECTED[i].want);
    drain_and_settle();

    // zero codes: extended keys buffer nothing
    load_codes('0);
    repeat (80) random_event(35);
    drain_and_settle();

    // all-ones codes, then overfill the ring
    load_codes({NumCfg{8'hFF}});
    repeat (300) begin
      if ($urandom_range(0, 49) == 0) random_event(0);
      else put_word(1'b0, {1'b0, 7'($urandom_range(16, 53))}, 1'b0);
    end
    drain_and_settle();

    load_codes(48'({$urandom, $urandom}));
    repeat (150) random_event(50);
    drain_and_settle();

    $display("run covered %0d words in, %0d characters read back, %0d lost to overflow",
             words_in, chars_read, overflow_drops);
    $display("key codes tried at reset values, all zero, all ones and one random set");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
